// File: sv/rsa_pkg.sv
package rsa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int WINDOW_DEF    = 1000;
    localparam int SPEED_W       = 24;
    localparam int DELTA_W       = 12;
    localparam int TRIG_W        = 12;
    localparam int FACTOR_W      = 12;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int MS_PER_S      = 1000;
    localparam int ACCEL_ONE     = 256;
    localparam int TRIG_MAX      = 4095;

    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_THRESHOLD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_ENABLE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOW_SPEED     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAST_SPEED     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ACCEL      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_SMOOTHING      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_ADJUST_TIMEOUT = 3'd6;

    localparam logic [8:0]  RST_BASE_THRESHOLD = 9'd15;
    localparam logic        RST_ACCEL_ENABLE   = 1'b1;
    localparam logic [15:0] RST_SLOW_SPEED     = 16'd100;
    localparam logic [15:0] RST_FAST_SPEED     = 16'd500;
    localparam logic [11:0] RST_MAX_ACCEL      = 12'd1024;
    localparam logic [8:0]  RST_SMOOTHING      = 9'd77;
    localparam logic [15:0] RST_ADJUST_TIMEOUT = 16'd300;

    typedef struct packed {
        logic                      req_type;
        logic signed [DELTA_W-1:0] delta_degrees;
    } t_in;

    typedef struct packed {
        logic signed [31:0]  knob_value;
        logic [TRIG_W-1:0]   trigger_count;
        logic                turn_clockwise;
        logic                adjusting;
    } t_out;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

endpackage

// File: sv/rsa_divider.sv
module rsa_divider #(
    parameter int DW = 36
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [DW-1:0]   i_num,
    input  logic [DW-1:0]   i_den,
    output logic            o_done,
    output logic [DW-1:0]   o_quot,
    output logic [DW-1:0]   o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [DW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   n_trial;
    logic          n_ge;

    always_comb begin
        n_trial = {r_rem, r_q[DW-1]};
        n_ge    = n_trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(DW);
            r_done <= 1'b0;
            r_q    <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            r_q   <= {r_q[DW-2:0], n_ge};
            r_rem <= n_ge ? DW'(n_trial - {1'b0, r_den}) : n_trial[DW-1:0];
            if (r_cnt == CW'(1)) begin
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

// File: sv/rotary_step_accelerator.sv
// Each rotation event uses one shared bit-serial divider of numerator width DW (36 at 8
// fractional bits). Up to four divisions run in turn, one quotient bit per cycle: speed,
// factor, threshold, trigger count. Speed is skipped outside the timing window, factor outside
// the slow-fast range, factor and threshold when acceleration is off. A new event is taken
// only in idle, after the previous result is registered for output; ticks and zero deltas stay idle.
// Reset is synchronous and active low; it clears FSM and knob state, loads register defaults.
module rotary_step_accelerator #(
    parameter int FRAC_BITS = rsa_pkg::FRAC_BITS_DEF,
    parameter int WINDOW_MS = rsa_pkg::WINDOW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  rsa_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rsa_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_we,
    input  logic [rsa_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [rsa_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SW  = rsa_pkg::SPEED_W;
    localparam int DW  = (21 + FRAC_BITS > 36) ? 21 + FRAC_BITS : 36;
    localparam int AW  = 13 + FRAC_BITS;
    localparam int EW  = 9 + FRAC_BITS;
    localparam int MSW = $clog2(WINDOW_MS + 1);
    localparam int FW  = rsa_pkg::FACTOR_W;
    localparam int TW  = rsa_pkg::TRIG_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DWAIT  = 4'd1;
    localparam logic [3:0] S_INST   = 4'd2;
    localparam logic [3:0] S_SMOOTH = 4'd3;
    localparam logic [3:0] S_FACT   = 4'd4;
    localparam logic [3:0] S_FMUL   = 4'd5;
    localparam logic [3:0] S_FDONE  = 4'd6;
    localparam logic [3:0] S_EFF    = 4'd7;
    localparam logic [3:0] S_EDONE  = 4'd8;
    localparam logic [3:0] S_ACC    = 4'd9;
    localparam logic [3:0] S_TRIG   = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [8:0]  r_base_threshold;
    logic        r_accel_enable;
    logic [15:0] r_slow_speed;
    logic [15:0] r_fast_speed;
    logic [11:0] r_max_accel;
    logic [8:0]  r_smoothing;
    logic [15:0] r_adjust_timeout;

    logic [3:0]                  r_state;
    logic [3:0]                  r_ret;
    logic signed [AW-1:0]        r_acc;
    logic [SW-1:0]               r_speed;
    logic [MSW-1:0]              r_ms;
    logic [31:0]                 r_running;
    logic                        r_flag;
    logic [15:0]                 r_countdown;
    logic signed [rsa_pkg::DELTA_W-1:0] r_delta;
    logic [DW-1:0]               r_prod;
    logic [SW-1:0]               r_inst;
    logic [FW-1:0]               r_factor;
    logic [EW-1:0]               r_eff;
    logic [DW-1:0]               r_num;
    logic [DW-1:0]               r_den;
    logic                        r_start;
    logic                        r_out_valid;
    rsa_pkg::t_out               r_out;

    rsa_pkg::t_div_ctl           n_div;
    logic [DW-1:0]               n_quot;
    logic [DW-1:0]               n_rem;
    logic [8:0]                  n_base;
    logic [8:0]                  n_w;
    logic [FW-1:0]               n_mx;
    logic [DW-1:0]               n_slo;
    logic [DW-1:0]               n_fst;
    logic [DW-1:0]               n_spd;
    logic [11:0]                 n_mag;
    logic [AW-1:0]               n_abs;
    logic signed [AW-1:0]        n_dsh;
    logic                        n_cw;
    logic                        n_start;
    logic                        n_emit;

    assign n_div.start = r_start;

    rsa_divider #(.DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div.start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (n_div.done),
        .o_quot  (n_quot),
        .o_rem   (n_rem)
    );

    always_comb begin
        n_base = (r_base_threshold == '0) ? 9'd1 : r_base_threshold;
        n_w    = (r_smoothing > 9'd256) ? 9'd256 : r_smoothing;
        n_mx   = (r_max_accel < FW'(rsa_pkg::ACCEL_ONE)) ? FW'(rsa_pkg::ACCEL_ONE) : r_max_accel;
        n_slo  = DW'(r_slow_speed) << FRAC_BITS;
        n_fst  = DW'(r_fast_speed) << FRAC_BITS;
        n_spd  = DW'(r_speed);
        n_mag  = i_in_data.delta_degrees[11] ? 12'(-i_in_data.delta_degrees)
                                             : 12'(i_in_data.delta_degrees);
        n_abs  = r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
        n_dsh  = AW'(r_delta) <<< FRAC_BITS;
        n_cw   = (r_acc > 0);
        n_emit = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
        n_start = ((r_state == S_IDLE) && i_in_valid && !i_in_data.req_type
                   && (i_in_data.delta_degrees != '0)
                   && (r_ms != '0) && (r_ms < MSW'(WINDOW_MS)))
                  || (r_state == S_FMUL) || (r_state == S_EFF) || (r_state == S_TRIG);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_threshold <= rsa_pkg::RST_BASE_THRESHOLD;
            r_accel_enable   <= rsa_pkg::RST_ACCEL_ENABLE;
            r_slow_speed     <= rsa_pkg::RST_SLOW_SPEED;
            r_fast_speed     <= rsa_pkg::RST_FAST_SPEED;
            r_max_accel      <= rsa_pkg::RST_MAX_ACCEL;
            r_smoothing      <= rsa_pkg::RST_SMOOTHING;
            r_adjust_timeout <= rsa_pkg::RST_ADJUST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rsa_pkg::CFG_BASE_THRESHOLD: r_base_threshold <= i_cfg_data[8:0];
                rsa_pkg::CFG_ACCEL_ENABLE:   r_accel_enable   <= i_cfg_data[0];
                rsa_pkg::CFG_SLOW_SPEED:     r_slow_speed     <= i_cfg_data;
                rsa_pkg::CFG_FAST_SPEED:     r_fast_speed     <= i_cfg_data;
                rsa_pkg::CFG_MAX_ACCEL:      r_max_accel      <= i_cfg_data[11:0];
                rsa_pkg::CFG_SMOOTHING:      r_smoothing      <= i_cfg_data[8:0];
                rsa_pkg::CFG_ADJUST_TIMEOUT: r_adjust_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_acc       <= '0;
            r_speed     <= '0;
            r_ms        <= '0;
            r_running   <= '0;
            r_flag      <= 1'b0;
            r_countdown <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= n_start;
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in_data.req_type) begin
                            if (r_ms < MSW'(WINDOW_MS)) begin
                                r_ms <= r_ms + 1'b1;
                            end
                            if (r_flag) begin
                                if (r_countdown <= 16'd1) begin
                                    r_flag      <= 1'b0;
                                    r_countdown <= '0;
                                end else begin
                                    r_countdown <= r_countdown - 1'b1;
                                end
                            end
                        end else if (i_in_data.delta_degrees != '0) begin
                            r_delta     <= i_in_data.delta_degrees;
                            r_flag      <= 1'b1;
                            r_countdown <= r_adjust_timeout;
                            r_ms        <= '0;
                            if (r_ms != '0 && r_ms < MSW'(WINDOW_MS)) begin
                                r_num   <= DW'(DW'(n_mag) * DW'(rsa_pkg::MS_PER_S)) << FRAC_BITS;
                                r_den   <= DW'(r_ms);
                                r_ret   <= S_INST;
                                r_state <= S_DWAIT;
                            end else begin
                                r_state <= S_FACT;
                            end
                        end
                    end
                end
                S_DWAIT: begin
                    if (n_div.done && !r_start) begin
                        r_state <= r_ret;
                    end
                end
                S_INST: begin
                    r_inst  <= (|n_quot[DW-1:SW]) ? {SW{1'b1}} : n_quot[SW-1:0];
                    r_prod  <= DW'(r_speed) * DW'(9'd256 - n_w);
                    r_state <= S_SMOOTH;
                end
                S_SMOOTH: begin
                    r_speed <= SW'((r_prod + DW'(r_inst) * DW'(n_w)) >> 8);
                    r_state <= S_FACT;
                end
                S_FACT: begin
                    if (!r_accel_enable) begin
                        r_eff   <= EW'(n_base) << FRAC_BITS;
                        r_state <= S_ACC;
                    end else if (n_spd < n_slo) begin
                        r_factor <= FW'(rsa_pkg::ACCEL_ONE);
                        r_state  <= S_EFF;
                    end else if (n_spd < n_fst) begin
                        r_prod  <= DW'(n_spd - n_slo) * DW'(n_mx - FW'(rsa_pkg::ACCEL_ONE));
                        r_state <= S_FMUL;
                    end else begin
                        r_factor <= n_mx;
                        r_state  <= S_EFF;
                    end
                end
                S_FMUL: begin
                    r_num   <= r_prod;
                    r_den   <= n_fst - n_slo;
                    r_ret   <= S_FDONE;
                    r_state <= S_DWAIT;
                end
                S_FDONE: begin
                    r_factor <= FW'(rsa_pkg::ACCEL_ONE) + n_quot[FW-1:0];
                    r_state  <= S_EFF;
                end
                S_EFF: begin
                    r_num   <= DW'(n_base) << (FRAC_BITS + 8);
                    r_den   <= DW'(r_factor);
                    r_ret   <= S_EDONE;
                    r_state <= S_DWAIT;
                end
                S_EDONE: begin
                    r_eff   <= (n_quot == '0) ? EW'(1) : n_quot[EW-1:0];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc     <= r_acc + n_dsh;
                    r_running <= r_running + 32'(r_delta);
                    r_state   <= S_TRIG;
                end
                S_TRIG: begin
                    r_num   <= DW'(n_abs);
                    r_den   <= DW'(r_eff);
                    r_ret   <= S_DONE;
                    r_state <= S_DWAIT;
                end
                S_DONE: begin
                    if (n_emit) begin
                        r_out.knob_value <= r_running;
                        r_out.adjusting  <= r_flag;
                        if (n_quot != '0) begin
                            r_out.turn_clockwise <= n_cw;
                            r_acc <= n_cw ? AW'(n_rem) : AW'(-n_rem);
                            r_out.trigger_count <= (n_quot > DW'(rsa_pkg::TRIG_MAX))
                                ? TW'(rsa_pkg::TRIG_MAX) : n_quot[TW-1:0];
                        end else begin
                            r_out.turn_clockwise <= 1'b0;
                            r_out.trigger_count  <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: tb/tb_top.sv
module tb_top;

    localparam int IDLE_WAIT     = 4 * (36 + 2) + 40;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int CFG_AW        = rsa_pkg::CFG_ADDR_W;
    localparam int CFG_DW        = rsa_pkg::CFG_DATA_W;
    localparam int DLW           = rsa_pkg::DELTA_W;
    localparam int TRW           = rsa_pkg::TRIG_W;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    rsa_pkg::t_in   i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    rsa_pkg::t_out  o_out_data;
    logic           i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_DW-1:0] i_cfg_data;

    rotary_step_accelerator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor copy of the registers and the knob state.
    logic [8:0]  m_base;
    logic        m_accel_en;
    logic [15:0] m_slow;
    logic [15:0] m_fast;
    logic [11:0] m_max_accel;
    logic [8:0]  m_smooth;
    logic [15:0] m_timeout;
    longint      m_accum;
    logic [23:0] m_speed;
    int          m_ms_idle;
    logic [31:0] m_knob;
    logic        m_adjusting;
    logic [15:0] m_countdown;

    rsa_pkg::t_out expected_steps[$];
    int     mismatches;
    int     quiet_cycles;
    bit     hold_receiver;
    int     hold_cycles;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic longint accel_factor(input longint speed);
        longint slo;
        longint fst;
        longint mx;
        slo = longint'(m_slow) << 8;
        fst = longint'(m_fast) << 8;
        mx  = (m_max_accel < rsa_pkg::ACCEL_ONE) ? rsa_pkg::ACCEL_ONE : m_max_accel;
        if (speed < slo) return rsa_pkg::ACCEL_ONE;
        if (speed < fst) begin
            return rsa_pkg::ACCEL_ONE + ((speed - slo) * (mx - rsa_pkg::ACCEL_ONE)) / (fst - slo);
        end
        return mx;
    endfunction

    task automatic predict_step(input rsa_pkg::t_in item);
        longint delta;
        longint mag;
        longint inst;
        longint w;
        longint eff;
        longint absacc;
        longint trig;
        longint elapsed;
        rsa_pkg::t_out res;
        if (item.req_type) begin
            if (m_ms_idle < rsa_pkg::WINDOW_DEF) m_ms_idle++;
            if (m_adjusting) begin
                if (m_countdown <= 1) begin
                    m_adjusting = 1'b0;
                    m_countdown = '0;
                end else begin
                    m_countdown--;
                end
            end
            return;
        end
        delta = item.delta_degrees;
        if (delta == 0) return;
        mag = (delta < 0) ? -delta : delta;
        m_adjusting = 1'b1;
        m_countdown = m_timeout;
        elapsed = m_ms_idle;
        m_ms_idle = 0;
        if (elapsed > 0 && elapsed < rsa_pkg::WINDOW_DEF) begin
            inst = ((mag * rsa_pkg::MS_PER_S) << 8) / elapsed;
            if (inst > 64'hFFFFFF) inst = 64'hFFFFFF;
            w = (m_smooth > 256) ? 256 : m_smooth;
            m_speed = 24'((longint'(m_speed) * (256 - w) + inst * w) >> 8);
        end
        eff = (m_base == 0) ? 1 : m_base;
        if (m_accel_en) eff = (eff << 16) / accel_factor(m_speed);
        else eff = eff << 8;
        if (eff == 0) eff = 1;
        m_accum += delta * 256;
        m_knob += 32'(delta);
        absacc = (m_accum < 0) ? -m_accum : m_accum;
        trig = absacc / eff;
        res.turn_clockwise = 1'b0;
        if (trig > 0) begin
            res.turn_clockwise = (m_accum > 0);
            m_accum = res.turn_clockwise ? (absacc % eff) : -(absacc % eff);
            if (trig > rsa_pkg::TRIG_MAX) trig = rsa_pkg::TRIG_MAX;
        end
        res.knob_value    = m_knob;
        res.trigger_count = TRW'(trig);
        res.adjusting     = m_adjusting;
        expected_steps.push_back(res);
    endtask

    task automatic write_register(input logic [CFG_AW-1:0] idx, input int value);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = CFG_DW'(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            rsa_pkg::CFG_BASE_THRESHOLD: m_base      = 9'(value);
            rsa_pkg::CFG_ACCEL_ENABLE:   m_accel_en  = 1'(value);
            rsa_pkg::CFG_SLOW_SPEED:     m_slow      = 16'(value);
            rsa_pkg::CFG_FAST_SPEED:     m_fast      = 16'(value);
            rsa_pkg::CFG_MAX_ACCEL:      m_max_accel = 12'(value);
            rsa_pkg::CFG_SMOOTHING:      m_smooth    = 9'(value);
            rsa_pkg::CFG_ADJUST_TIMEOUT: m_timeout   = 16'(value);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (expected_steps.size() != 0) @(negedge i_clk);
        repeat (IDLE_WAIT) @(negedge i_clk);
    endtask

    task automatic apply_settings(input int base, input int en, input int slo, input int fst,
                                  input int mx, input int sm, input int tmo);
        wait_drained();
        write_register(rsa_pkg::CFG_BASE_THRESHOLD, base);
        write_register(rsa_pkg::CFG_ACCEL_ENABLE, en);
        write_register(rsa_pkg::CFG_SLOW_SPEED, slo);
        write_register(rsa_pkg::CFG_FAST_SPEED, fst);
        write_register(rsa_pkg::CFG_MAX_ACCEL, mx);
        write_register(rsa_pkg::CFG_SMOOTHING, sm);
        write_register(rsa_pkg::CFG_ADJUST_TIMEOUT, tmo);
    endtask

    task automatic send_item(input logic kind, input int delta, input bit no_gap = 0);
        rsa_pkg::t_in item;
        int  gap;
        if (!no_gap) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) gap = 0;
            repeat (gap) @(negedge i_clk);
        end
        item.req_type      = kind;
        item.delta_degrees = DLW'(delta);
        i_in_valid = 1'b1;
        i_in_data  = item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_step(item);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(1'b1, 0, 1);
    endtask

    task automatic random_delta(output int d);
        case ($urandom_range(0, 5))
            0: d = $urandom_range(0, 4095) - 2048;
            1: d = ($urandom_range(0, 1) ? 2047 : -2048);
            default: d = $urandom_range(1, 60) * ($urandom_range(0, 1) ? 1 : -1);
        endcase
    endtask

    task automatic test_directed_extremes();
        send_item(1'b0, 0);
        send_item(1'b0, 2047);
        send_item(1'b0, -2048);
        send_item(1'b0, 1);
        send_item(1'b0, -1);
        send_ticks(1);
        send_item(1'b0, 5);
        send_ticks(998);
        send_item(1'b0, 30);
        send_ticks(1005);
        send_item(1'b0, -30);
        send_ticks(1);
        send_item(1'b0, 2047);
        send_ticks(2);
        send_item(1'b0, 2047);
        send_item(1'b0, -1365);
        send_item(1'b0, 0);
    endtask

    task automatic test_adjust_timeout();
        apply_settings(15, 1, 100, 500, 1024, 77, 0);
        send_item(1'b0, 10);
        send_ticks(1);
        send_item(1'b0, 10);
        wait_drained();
        write_register(rsa_pkg::CFG_ADJUST_TIMEOUT, 3);
        send_item(1'b0, 20);
        send_ticks(2);
        send_item(1'b0, 3);
        send_ticks(4);
        send_item(1'b0, -3);
    endtask

    task automatic run_random(input int n);
        int d;
        repeat (n) begin
            if ($urandom_range(0, 2) == 0) begin
                send_ticks($urandom_range(1, 40));
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(1'b0, 0);
                end else begin
                    random_delta(d);
                    send_item(1'b0, d);
                end
            end
        end
    endtask

    task automatic test_random_settings();
        apply_settings(0, 1, 0, 1, 0, 300, 65535);
        run_random(50);
        apply_settings(360, 1, 65535, 65535, 4095, 256, 1);
        run_random(50);
        apply_settings(1, 1, 0, 65535, 4095, 0, 20);
        run_random(50);
        apply_settings(7, 1, 10, 40, 4095, 200, 50);
        run_random(70);
        apply_settings(15, 0, 100, 500, 1024, 77, 300);
        run_random(50);
        apply_settings($urandom_range(1, 360), 1, $urandom_range(0, 200),
                       $urandom_range(201, 3000), $urandom_range(256, 4095),
                       $urandom_range(0, 511), $urandom_range(1, 100));
        run_random(80);
    endtask

    task automatic test_backpressure();
        int d;
        hold_cycles   = 2000;
        hold_receiver = 1'b1;
        repeat (12) begin
            random_delta(d);
            send_item(1'b0, d, 1);
        end
        while (expected_steps.size() != 0) @(negedge i_clk);
        repeat (8) begin
            send_ticks(3);
            send_item(1'b0, $urandom_range(1, 90));
        end
    endtask

    // Receiver: random stalls, with a long hold-off when asked.
    always @(negedge i_clk) begin
        if (hold_receiver) begin
            i_out_ready <= 1'b0;
            if (hold_cycles > 0) hold_cycles--;
            else hold_receiver = 1'b0;
        end else if ($urandom_range(0, 19) == 0) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_steps.size() == 0) begin
                report_mismatch("unexpected transfer", 0, 0);
            end else begin
                rsa_pkg::t_out want;
                want = expected_steps.pop_front();
                if (o_out_data.knob_value !== want.knob_value)
                    report_mismatch("knob_value", o_out_data.knob_value, want.knob_value);
                if (o_out_data.trigger_count !== want.trigger_count)
                    report_mismatch("trigger_count", o_out_data.trigger_count,
                                    want.trigger_count);
                if (o_out_data.turn_clockwise !== want.turn_clockwise)
                    report_mismatch("turn_clockwise", o_out_data.turn_clockwise,
                                    want.turn_clockwise);
                if (o_out_data.adjusting !== want.adjusting)
                    report_mismatch("adjusting", o_out_data.adjusting, want.adjusting);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        mismatches    = 0;
        quiet_cycles  = 0;
        hold_receiver = 1'b0;
        hold_cycles   = 0;
        m_base = rsa_pkg::RST_BASE_THRESHOLD;
        m_accel_en = rsa_pkg::RST_ACCEL_ENABLE;
        m_slow = rsa_pkg::RST_SLOW_SPEED;
        m_fast = rsa_pkg::RST_FAST_SPEED;
        m_max_accel = rsa_pkg::RST_MAX_ACCEL;
        m_smooth = rsa_pkg::RST_SMOOTHING;
        m_timeout = rsa_pkg::RST_ADJUST_TIMEOUT;
        m_accum = 0;
        m_speed = '0;
        m_ms_idle = 0;
        m_knob = '0;
        m_adjusting = 1'b0;
        m_countdown = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_extremes();
        test_adjust_timeout();
        test_random_settings();
        test_backpressure();
        wait_drained();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
